// ----- rtl/lpsc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lpsc_pkg
// Shared types and constants of the looping playhead with speed curve.
// ----------------------------------------------------------------------------
package lpsc_pkg;

    localparam int MAX_CURVE_POINTS = 8;
    localparam int CIDX_W = $clog2(MAX_CURVE_POINTS);
    localparam int CNT_W  = $clog2(MAX_CURVE_POINTS + 1);

    localparam int DIV_W  = 34;
    localparam int DIV_CW = 6;

    localparam logic signed [15:0] ONE_Q12 = 16'sd4096;
    localparam logic [16:0] T_ONE = 17'd65536;

    // mode_flags bit positions
    localparam int MF_LOOP  = 0;
    localparam int MF_STOP  = 1;
    localparam int MF_RANGE = 2;
    localparam int MF_RLOOP = 3;
    localparam int MF_CURVE = 4;
    localparam int MF_CINR  = 5;

    // configuration register indexes
    localparam logic [2:0] REG_CLIP  = 3'd0;
    localparam logic [2:0] REG_SPEED = 3'd1;
    localparam logic [2:0] REG_MODE  = 3'd2;
    localparam logic [2:0] REG_RSTA  = 3'd3;
    localparam logic [2:0] REG_REND  = 3'd4;
    localparam logic [2:0] REG_NPTS  = 3'd5;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_HOLD  = 2'd2,
        CMD_LOAD  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  rem0;
        logic [DIV_W-1:0]  dvd;
        logic [DIV_W-1:0]  dvs;
        logic [DIV_CW-1:0] cnt;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/looping_playhead_speed_curve.sv -----
`default_nettype none
// Every result is registered in ST_FIN; a tick that advances first runs the computation
// states, using the shared serial divider for the curve time, the curve interpolation
// and a wrap, besides a search of the curve points.
// Throughput: one command at a time; the next transfer is taken the cycle after
// the result is registered, later while a result waits on i_m_tready.
// Reset (synchronous, active low) sets the state, playhead, run, done, hold, output valid and registers.
// ----------------------------------------------------------------------------
// looping_playhead_speed_curve
// Variable-rate playhead with hold override, speed curve and loop/clamp.
// ----------------------------------------------------------------------------
module looping_playhead_speed_curve (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // tick_time[19:0] seek_position[51:20] hold_duration[71:52]
    // hold_scale[86:72] point_index[89:87] point_abscissa[106:90]
    // point_value[122:107]
    input  wire logic [127:0] i_s_tdata,
    // command[1:0]
    input  wire logic [1:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // position[31:0] is_playing[32] is_finished[33] hold_left[53:34]
    // applied_scale[69:54]
    output logic [71:0]       o_m_tdata,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);
    import lpsc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_TSCL, ST_NORM, ST_NWAIT, ST_CV0, ST_CVL, ST_SCAN, ST_IMUL,
        ST_IDIV, ST_IWAIT, ST_SMUL, ST_SSAT, ST_DMUL1, ST_DMUL2, ST_POSC,
        ST_BND, ST_MWAIT, ST_FIN
    } t_state;

    typedef enum logic [1:0] {MM_RANGE, MM_CLIP, MM_NEG} t_mm;

    t_state r_state;
    t_mm    r_mm;

    logic [30:0]        r_clip;
    logic signed [15:0] r_speed;
    logic [5:0]         r_mode;
    logic signed [31:0] r_rs;
    logic signed [31:0] r_re;
    logic [3:0]         r_npts;

    logic signed [31:0] r_ph;
    logic               r_run;
    logic               r_done;
    logic [19:0]        r_hold;
    logic [14:0]        r_hfac;

    logic [19:0]        r_dt;
    logic signed [15:0] r_scale;
    logic [16:0]        r_t;
    logic [CIDX_W-1:0]  r_j;
    logic [16:0]        r_px;
    logic signed [15:0] r_pv;
    logic signed [15:0] r_cur;
    logic signed [16:0] r_dv;
    logic [16:0]        r_dtc;
    logic [16:0]        r_den;
    logic signed [34:0] r_prod;
    logic               r_neg;
    logic signed [31:0] r_sp;
    logic signed [36:0] r_p1;
    logic signed [52:0] r_p2;
    logic signed [33:0] r_pos;

    logic        r_ov;
    logic [71:0] r_od;

    t_div_req r_dreq;
    t_div_rsp w_drsp;

    logic               w_s_acc;
    t_cmd               w_cmd;
    logic               w_wr_en;
    logic [CIDX_W-1:0]  w_rd_addr;
    logic [32:0]        w_rd_data;
    logic [16:0]        w_rd_x;
    logic signed [15:0] w_rd_v;
    logic [CNT_W-1:0]   w_n;
    logic signed [15:0] w_scl0;
    logic signed [32:0] w_num;
    logic signed [32:0] w_den;
    logic               w_tz;
    logic signed [17:0] w_r;
    logic signed [16:0] w_dv;
    logic [32:0]        w_sp_mag;
    logic signed [63:0] w_sp_q;
    logic [52:0]        w_p2_mag;
    logic signed [33:0] w_delta;
    logic               w_use_rng;
    logic               w_wrap;
    logic signed [33:0] w_lo;
    logic signed [33:0] w_hi;
    logic signed [33:0] w_len;
    logic signed [63:0] w_iq;

    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_cmd       = t_cmd'(i_s_tuser);
    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ov;
    assign o_m_tdata   = r_od;

    assign w_wr_en = w_s_acc && (w_cmd == CMD_LOAD)
                     && (32'(i_s_tdata[89:87]) < MAX_CURVE_POINTS);

    // point word: abscissa[16:0] value[32:17]
    assign w_rd_x = w_rd_data[16:0];
    assign w_rd_v = w_rd_data[32:17];

    lpsc_curve #(
        .WIDTH (33),
        .DEPTH (MAX_CURVE_POINTS)
    ) u_curve (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (CIDX_W'(i_s_tdata[89:87])),
        .i_wr_data (i_s_tdata[122:90]),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    lpsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_dreq),
        .o_rsp   (w_drsp)
    );

    always_comb begin
        if (32'(r_npts) > MAX_CURVE_POINTS) begin
            w_n = CNT_W'(MAX_CURVE_POINTS);
        end else begin
            w_n = CNT_W'(r_npts);
        end
        // read address is given in the state before the one that uses the point, as the read is registered
        case (r_state)
            ST_CV0:  w_rd_addr = CIDX_W'(w_n - 1'b1);
            ST_CVL:  w_rd_addr = CIDX_W'(1);
            ST_SCAN: w_rd_addr = r_j + 1'b1;
            default: w_rd_addr = '0;
        endcase

        w_scl0 = (r_hold != '0) ? $signed({1'b0, r_hfac}) : ONE_Q12;

        if (r_mode[MF_CINR]) begin
            w_num = 33'(r_ph) - 33'(r_rs);
            w_den = 33'(r_re) - 33'(r_rs);
            w_tz  = (w_den <= 0);
        end else begin
            w_num = 33'(r_ph);
            w_den = $signed({2'b0, r_clip});
            w_tz  = 1'b0;
        end

        w_r  = $signed({1'b0, w_rd_x}) - $signed({1'b0, r_px});
        w_dv = 17'(w_rd_v) - 17'(r_pv);

        w_iq = r_neg ? -$signed(64'(w_drsp.quo)) : $signed(64'(w_drsp.quo));

        w_sp_mag = r_sp[31] ? 33'(-(33'(r_sp))) : 33'(r_sp);
        w_sp_q   = r_sp[31] ? -$signed(64'(w_sp_mag >> 12))
                            : $signed(64'(w_sp_mag >> 12));

        w_p2_mag = r_p2[52] ? 53'(-r_p2) : 53'(r_p2);
        w_delta  = r_p2[52] ? -$signed(34'(w_p2_mag >> 24))
                            : $signed(34'(w_p2_mag >> 24));

        w_use_rng = r_mode[MF_RANGE] && (r_re > r_rs);
        w_lo  = 34'(r_rs);
        w_hi  = 34'(r_re);
        w_len = $signed({3'b0, r_clip});

        if (w_use_rng) begin
            w_wrap = (r_pos >= w_hi) && r_mode[MF_RLOOP];
        end else begin
            w_wrap = r_mode[MF_LOOP] && ((r_pos >= w_len) || (r_pos < 0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_clip       <= '0;
            r_speed      <= ONE_Q12;
            r_mode       <= '0;
            r_rs         <= '0;
            r_re         <= '0;
            r_npts       <= '0;
            r_ph         <= '0;
            r_run        <= 1'b0;
            r_done       <= 1'b0;
            r_hold       <= '0;
            r_hfac       <= '0;
            r_ov         <= 1'b0;
            r_dreq.start <= 1'b0;
        end else begin
            if (r_ov && i_m_tready && r_state != ST_FIN) begin
                r_ov <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_CLIP:  r_clip  <= i_cfg_data[30:0];
                    REG_SPEED: r_speed <= i_cfg_data[15:0];
                    REG_MODE:  r_mode  <= i_cfg_data[5:0];
                    REG_RSTA:  r_rs    <= i_cfg_data;
                    REG_REND:  r_re    <= i_cfg_data;
                    REG_NPTS:  r_npts  <= i_cfg_data[3:0];
                    default: ;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_s_acc) begin
                        r_dt    <= i_s_tdata[19:0];
                        r_scale <= '0;
                        r_state <= (w_cmd == CMD_TICK && r_run && r_clip != '0)
                                   ? ST_TSCL : ST_FIN;
                        case (w_cmd)
                            CMD_TICK: begin
                                if (r_run && r_clip == '0) begin
                                    if (r_mode[MF_STOP] && !r_mode[MF_LOOP]) begin
                                        r_run  <= 1'b0;
                                        r_done <= 1'b1;
                                    end
                                end
                            end
                            CMD_START: begin
                                r_ph   <= i_s_tdata[51:20];
                                r_run  <= 1'b1;
                                r_done <= 1'b0;
                            end
                            CMD_HOLD: begin
                                r_hold <= i_s_tdata[71:52];
                                r_hfac <= i_s_tdata[86:72];
                            end
                            default: ;
                        endcase
                    end
                end
                ST_TSCL: begin
                    r_scale <= w_scl0;
                    if (r_hold != '0) begin
                        r_hold <= (r_hold > r_dt) ? r_hold - r_dt : '0;
                    end
                    r_state <= (r_mode[MF_CURVE] && w_scl0 > 0) ? ST_NORM : ST_DMUL1;
                end
                ST_NORM: begin
                    if (w_tz || w_num <= 0) begin
                        r_t     <= '0;
                        r_state <= ST_CV0;
                    end else if (w_num >= w_den) begin
                        r_t     <= T_ONE;
                        r_state <= ST_CV0;
                    end else begin
                        r_dreq.start <= 1'b1;
                        r_dreq.rem0  <= DIV_W'(unsigned'(w_num));
                        r_dreq.dvd   <= '0;
                        r_dreq.dvs   <= DIV_W'(unsigned'(w_den));
                        r_dreq.cnt   <= DIV_CW'(16);
                        r_state      <= ST_NWAIT;
                    end
                end
                ST_NWAIT: begin
                    r_dreq.start <= 1'b0;
                    if (w_drsp.done) begin
                        r_t     <= {1'b0, w_drsp.quo[15:0]};
                        r_state <= ST_CV0;
                    end
                end
                ST_CV0: begin
                    if (w_n == '0) begin
                        r_cur   <= ONE_Q12;
                        r_state <= ST_SMUL;
                    end else if (r_t <= w_rd_x) begin
                        r_cur   <= w_rd_v;
                        r_state <= ST_SMUL;
                    end else begin
                        r_px    <= w_rd_x;
                        r_pv    <= w_rd_v;
                        r_state <= ST_CVL;
                    end
                end
                ST_CVL: begin
                    if (r_t >= w_rd_x) begin
                        r_cur   <= w_rd_v;
                        r_state <= ST_SMUL;
                    end else begin
                        r_j     <= CIDX_W'(1);
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_t <= w_rd_x) begin
                        if (w_r <= 0) begin
                            r_cur   <= r_pv;
                            r_state <= ST_SMUL;
                        end else begin
                            r_dv    <= w_dv;
                            r_dtc   <= r_t - r_px;
                            r_den   <= w_r[16:0];
                            r_state <= ST_IMUL;
                        end
                    end else if (CNT_W'(r_j) == w_n - 1'b1) begin
                        r_cur   <= ONE_Q12;
                        r_state <= ST_SMUL;
                    end else begin
                        r_px <= w_rd_x;
                        r_pv <= w_rd_v;
                        r_j  <= r_j + 1'b1;
                    end
                end
                ST_IMUL: begin
                    r_prod  <= r_dv * $signed({1'b0, r_dtc});
                    r_state <= ST_IDIV;
                end
                ST_IDIV: begin
                    r_neg        <= r_prod[34];
                    r_dreq.start <= 1'b1;
                    r_dreq.rem0  <= '0;
                    r_dreq.dvd   <= r_prod[34] ? DIV_W'(-r_prod) : DIV_W'(r_prod);
                    r_dreq.dvs   <= DIV_W'(r_den);
                    r_dreq.cnt   <= DIV_CW'(DIV_W);
                    r_state      <= ST_IWAIT;
                end
                ST_IWAIT: begin
                    r_dreq.start <= 1'b0;
                    if (w_drsp.done) begin
                        r_cur   <= sat16(64'(r_pv) + w_iq);
                        r_state <= ST_SMUL;
                    end
                end
                ST_SMUL: begin
                    r_sp    <= r_scale * r_cur;
                    r_state <= ST_SSAT;
                end
                ST_SSAT: begin
                    r_scale <= sat16(w_sp_q);
                    r_state <= ST_DMUL1;
                end
                ST_DMUL1: begin
                    r_p1    <= $signed({1'b0, r_dt}) * r_speed;
                    r_state <= ST_DMUL2;
                end
                ST_DMUL2: begin
                    r_p2    <= r_p1 * r_scale;
                    r_state <= ST_POSC;
                end
                ST_POSC: begin
                    r_pos   <= 34'(r_ph) + w_delta;
                    r_state <= ST_BND;
                end
                ST_BND: begin
                    r_state <= w_wrap ? ST_MWAIT : ST_FIN;
                    if (w_use_rng) begin
                        if (r_pos >= w_hi) begin
                            if (r_mode[MF_RLOOP]) begin
                                r_dreq.start <= 1'b1;
                                r_dreq.rem0  <= '0;
                                r_dreq.dvd   <= DIV_W'(r_pos - w_lo);
                                r_dreq.dvs   <= DIV_W'(w_hi - w_lo);
                                r_dreq.cnt   <= DIV_CW'(DIV_W);
                                r_mm         <= MM_RANGE;
                            end else begin
                                r_ph <= r_re;
                                if (r_mode[MF_STOP]) begin
                                    r_run  <= 1'b0;
                                    r_done <= 1'b1;
                                end
                            end
                        end else if (r_pos < w_lo) begin
                            r_ph <= r_rs;
                        end else begin
                            r_ph <= r_pos[31:0];
                        end
                    end else begin
                        if (r_pos >= w_len) begin
                            if (r_mode[MF_LOOP]) begin
                                r_dreq.start <= 1'b1;
                                r_dreq.rem0  <= '0;
                                r_dreq.dvd   <= DIV_W'(r_pos);
                                r_dreq.dvs   <= DIV_W'(w_len);
                                r_dreq.cnt   <= DIV_CW'(DIV_W);
                                r_mm         <= MM_CLIP;
                            end else begin
                                r_ph <= {1'b0, r_clip};
                                if (r_mode[MF_STOP]) begin
                                    r_run  <= 1'b0;
                                    r_done <= 1'b1;
                                end
                            end
                        end else if (r_pos < 0) begin
                            if (r_mode[MF_LOOP]) begin
                                r_dreq.start <= 1'b1;
                                r_dreq.rem0  <= '0;
                                r_dreq.dvd   <= DIV_W'(-r_pos);
                                r_dreq.dvs   <= DIV_W'(w_len);
                                r_dreq.cnt   <= DIV_CW'(DIV_W);
                                r_mm         <= MM_NEG;
                            end else begin
                                r_ph <= '0;
                            end
                        end else begin
                            r_ph <= r_pos[31:0];
                        end
                    end
                end
                ST_MWAIT: begin
                    r_dreq.start <= 1'b0;
                    if (w_drsp.done) begin
                        case (r_mm)
                            MM_RANGE: r_ph <= r_rs + w_drsp.rem[31:0];
                            MM_CLIP:  r_ph <= w_drsp.rem[31:0];
                            default:  r_ph <= {1'b0, r_clip} - w_drsp.rem[31:0];
                        endcase
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_ov || i_m_tready) begin
                        r_ov    <= 1'b1;
                        r_od    <= {2'b0, r_scale, r_hold, r_done, r_run, r_ph};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> !o_s_tready)
        else $error("input taken while a command is in work");

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_run)
        else $error("finished playhead still running");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dreq.start |-> !w_drsp.busy)
        else $error("divider started while busy");

endmodule
`default_nettype wire

// ----- rtl/lpsc_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lpsc_div
// Radix-2 restoring divider, one quotient bit per cycle, preloadable remainder.
// ----------------------------------------------------------------------------
module lpsc_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lpsc_pkg::t_div_req i_req,
    output lpsc_pkg::t_div_rsp     o_rsp
);
    import lpsc_pkg::*;

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dvd;
    logic [DIV_W-1:0]  r_dvs;
    logic [DIV_W-1:0]  r_quo;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_W:0] w_sh;
    logic [DIV_W:0] w_diff;
    logic           w_ge;

    assign w_sh   = {r_rem, r_dvd[DIV_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_dvs};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.rem0;
                r_dvd  <= i_req.dvd;
                r_dvs  <= i_req.dvs;
                r_quo  <= '0;
                r_cnt  <= i_req.cnt;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_sh[DIV_W-1:0];
                r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
                r_quo <= {r_quo[DIV_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire

// ----- rtl/lpsc_curve.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lpsc_curve
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lpsc_curve #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]              o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ----- tb/playhead_checker.sv -----
// ----------------------------------------------------------------------------
// playhead_checker
// Watches the command, result and register channels of the playhead. It keeps
// its own copy of the registers, the playhead state and the speed curve. For
// each command transfer it works out the result, and it compares every result
// transfer, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module playhead_checker
    import lpsc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    input  wire logic [127:0] i_s_tdata,
    input  wire logic [1:0]   i_s_tuser,
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    input  wire logic [71:0]  i_m_tdata,
    input  wire logic         i_cfg_valid,
    input  wire logic         i_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_results
);

    typedef struct packed {
        logic [31:0] position;
        logic        playing;
        logic        finished;
        logic [19:0] hold_left;
        logic [15:0] scale;
    } t_report;

    t_report due_reports[$];

    // registers
    logic        [30:0] clip_len;
    logic signed [15:0] speed;
    logic        [5:0]  mode;
    logic signed [31:0] win_lo;
    logic signed [31:0] win_hi;
    logic        [3:0]  npts;

    // playhead state
    longint             head;
    bit                 run;
    bit                 fin;
    logic        [19:0] htimer;
    logic        [14:0] hfac;
    logic        [16:0] pt_x[MAX_CURVE_POINTS];
    logic signed [15:0] pt_v[MAX_CURVE_POINTS];

    function automatic longint clamp_q12(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint curve_time(input longint num, input longint den);
        if (num <= 0) return 0;
        if (num >= den) return 65536;
        return (num * 65536) / den;
    endfunction

    function automatic longint curve_factor(input longint t);
        int     n;
        longint r;
        n = (npts > MAX_CURVE_POINTS) ? MAX_CURVE_POINTS : int'(npts);
        if (n == 0) return 4096;
        if (t <= longint'(pt_x[0])) return longint'(pt_v[0]);
        if (t >= longint'(pt_x[n-1])) return longint'(pt_v[n-1]);
        for (int j = 0; j + 1 < n; j++) begin
            if (t <= longint'(pt_x[j+1])) begin
                r = longint'(pt_x[j+1]) - longint'(pt_x[j]);
                if (r < 1) return longint'(pt_v[j]);
                return clamp_q12(longint'(pt_v[j]) + ((longint'(pt_v[j+1]) -
                       longint'(pt_v[j])) * (t - longint'(pt_x[j]))) / r);
            end
        end
        return 4096;
    endfunction

    task automatic advance_playhead(input logic [19:0] dt, output longint sc);
        longint pos, lo, hi, len, t, w;
        sc = 4096;
        if (!run) begin
            sc = 0;
            return;
        end
        if (clip_len == 0) begin
            if (mode[MF_STOP] && !mode[MF_LOOP]) begin
                run = 0;
                fin = 1;
            end
            sc = 0;
            return;
        end
        if (htimer != 0) begin
            sc = longint'(hfac);
            htimer = (htimer > dt) ? htimer - dt : 20'd0;
        end
        if (mode[MF_CURVE] && sc > 0) begin
            if (mode[MF_CINR]) begin
                w = longint'(win_hi) - longint'(win_lo);
                t = (w > 0) ? curve_time(head - longint'(win_lo), w) : 0;
            end else begin
                t = curve_time(head, longint'(clip_len));
            end
            sc = clamp_q12((sc * curve_factor(t)) / 4096);
        end
        pos = head + (longint'(dt) * longint'(speed) * sc) / 16777216;
        lo = longint'(win_lo);
        hi = longint'(win_hi);
        if (mode[MF_RANGE] && hi > lo) begin
            if (pos >= hi) begin
                if (mode[MF_RLOOP]) begin
                    pos = lo + (pos - lo) % (hi - lo);
                end else begin
                    pos = hi;
                    if (mode[MF_STOP]) begin
                        run = 0;
                        fin = 1;
                    end
                end
            end else if (pos < lo) begin
                pos = lo;
            end
        end else begin
            len = longint'(clip_len);
            if (pos >= len) begin
                if (mode[MF_LOOP]) begin
                    pos = pos % len;
                end else begin
                    pos = len;
                    if (mode[MF_STOP]) begin
                        run = 0;
                        fin = 1;
                    end
                end
            end else if (pos < 0) begin
                pos = mode[MF_LOOP] ? len + (pos % len) : 0;
            end
        end
        head = pos;
    endtask

    task automatic report_field(input string name, input longint e, input longint a);
        $display("%0t: mismatch in %s: expected %0d, got %0d", $time, name, e, a);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_report exp_r;
        t_report got;
        longint  sc;
        t_cmd    cmd;
        if (!i_rst_n) begin
            clip_len  = '0;
            speed     = ONE_Q12;
            mode      = '0;
            win_lo    = '0;
            win_hi    = '0;
            npts      = '0;
            head      = 0;
            run       = 0;
            fin       = 0;
            htimer    = '0;
            hfac      = '0;
            o_errors  = 0;
            o_results = 0;
            due_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CLIP:  clip_len = i_cfg_data[30:0];
                    REG_SPEED: speed    = i_cfg_data[15:0];
                    REG_MODE:  mode     = i_cfg_data[5:0];
                    REG_RSTA:  win_lo   = i_cfg_data;
                    REG_REND:  win_hi   = i_cfg_data;
                    REG_NPTS:  npts     = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                sc  = 0;
                cmd = t_cmd'(i_s_tuser);
                case (cmd)
                    CMD_TICK: advance_playhead(i_s_tdata[19:0], sc);
                    CMD_START: begin
                        head = longint'($signed(i_s_tdata[51:20]));
                        run  = 1;
                        fin  = 0;
                    end
                    CMD_HOLD: begin
                        htimer = i_s_tdata[71:52];
                        hfac   = i_s_tdata[86:72];
                    end
                    CMD_LOAD: begin
                        pt_x[i_s_tdata[89:87]] = i_s_tdata[106:90];
                        pt_v[i_s_tdata[89:87]] = i_s_tdata[122:107];
                    end
                    default: ;
                endcase
                exp_r.position  = head[31:0];
                exp_r.playing   = run;
                exp_r.finished  = fin;
                exp_r.hold_left = htimer;
                exp_r.scale     = sc[15:0];
                due_reports.push_back(exp_r);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.position  = i_m_tdata[31:0];
                got.playing   = i_m_tdata[32];
                got.finished  = i_m_tdata[33];
                got.hold_left = i_m_tdata[53:34];
                got.scale     = i_m_tdata[69:54];
                o_results++;
                if (due_reports.size() == 0) begin
                    $display("%0t: result transfer with none due, got %h", $time, got);
                    o_errors++;
                end else begin
                    exp_r = due_reports.pop_front();
                    if (got.position != exp_r.position)
                        report_field("position", longint'($signed(exp_r.position)),
                                     longint'($signed(got.position)));
                    if (got.playing != exp_r.playing)
                        report_field("is_playing", exp_r.playing, got.playing);
                    if (got.finished != exp_r.finished)
                        report_field("is_finished", exp_r.finished, got.finished);
                    if (got.hold_left != exp_r.hold_left)
                        report_field("hold_left", exp_r.hold_left, got.hold_left);
                    if (got.scale != exp_r.scale)
                        report_field("applied_scale", longint'($signed(exp_r.scale)),
                                     longint'($signed(got.scale)));
                end
            end
        end
        o_pending = due_reports.size();
    end

endmodule

// ----- tb/tb_looping_playhead_speed_curve.sv -----
// ----------------------------------------------------------------------------
// tb_looping_playhead_speed_curve
// Drives commands and register writes into the playhead with random gaps and
// output stalls, across many register settings, and lets the checker judge
// every result transfer.
// ----------------------------------------------------------------------------
module tb_looping_playhead_speed_curve;
    import lpsc_pkg::*;

    localparam int ITEMS       = 950;
    localparam int QUIET_FROM  = 850;
    localparam int WATCH_LIMIT = 20000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [127:0] i_s_tdata;
    logic [1:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [71:0]  o_m_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    int errors, pending, results;
    int sent, ticks, settings;
    int idle_cycles = 0;
    bit tx_quiet, rx_quiet, long_stall_req;

    looping_playhead_speed_curve uut (.*);

    playhead_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        i_m_tready = 0;
        forever begin
            @(negedge i_clk);
            if (long_stall_req) begin
                long_stall_req = 0;
                i_m_tready <= 0;
                repeat (400) @(negedge i_clk);
            end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 0;
                repeat ($urandom_range(0, 17)) @(negedge i_clk);
            end else begin
                i_m_tready <= 1;
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCH_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_cmd(input t_cmd cmd, input logic [19:0] dt,
                            input logic [31:0] seek, input logic [19:0] hdur,
                            input logic [14:0] hscale, input logic [2:0] idx,
                            input logic [16:0] absc, input logic [15:0] val);
        if (!tx_quiet && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 0;
            repeat ($urandom_range(0, 17)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {5'd0, val, absc, idx, hscale, hdur, seek, dt};
        do @(posedge i_clk); while (!o_s_tready);
        sent++;
        if (cmd == CMD_TICK) ticks++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic quiesce();
        @(negedge i_clk);
        i_s_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [30:0] clip, input logic [15:0] spd,
                                  input logic [5:0] mf, input logic [31:0] lo,
                                  input logic [31:0] hi, input logic [3:0] np);
        quiesce();
        write_reg(REG_CLIP, {1'b0, clip});
        write_reg(REG_SPEED, {16'd0, spd});
        write_reg(REG_MODE, {26'd0, mf});
        write_reg(REG_RSTA, lo);
        write_reg(REG_REND, hi);
        write_reg(REG_NPTS, {28'd0, np});
        settings++;
    endtask

    task automatic random_settings();
        logic [30:0] clip;
        logic [15:0] spd;
        logic [31:0] lo, hi;
        case ($urandom_range(0, 5))
            0:       clip = '0;
            1:       clip = 31'h7FFF_FFFF;
            2:       clip = 31'($urandom);
            default: clip = 31'($urandom_range(1, 40) << 16) + 31'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 5))
            0:       spd = 16'h8000;
            1:       spd = 16'h7FFF;
            2:       spd = 16'($urandom);
            3:       spd = 16'(-$urandom_range(1, 8192));
            default: spd = 16'($urandom_range(1024, 12288));
        endcase
        case ($urandom_range(0, 4))
            0: begin
                lo = 32'h8000_0000;
                hi = 32'h7FFF_FFFF;
            end
            1: begin
                lo = $urandom;
                hi = $urandom;
            end
            2: begin
                hi = 32'($urandom_range(0, 20) << 16);
                lo = hi + 32'($urandom_range(0, 5) << 16);
            end
            default: begin
                lo = 32'($signed($urandom_range(0, 30) << 16)) - 32'sd655360;
                hi = lo + 32'($urandom_range(1, 20) << 16) + 32'($urandom_range(0, 65535));
            end
        endcase
        apply_settings(clip, spd, 6'($urandom), lo, hi, 4'($urandom_range(0, 8)));
    endtask

    task automatic random_cmd();
        logic [19:0] dt;
        logic [31:0] seek;
        int          k;
        k = $urandom_range(0, 99);
        if (k < 70) begin
            case ($urandom_range(0, 7))
                0:       dt = '0;
                1:       dt = 20'($urandom);
                2:       dt = 20'hFFFFF;
                default: dt = 20'($urandom_range(0, 40000));
            endcase
            send_cmd(CMD_TICK, dt, 32'($urandom), 20'($urandom), 15'($urandom),
                     3'($urandom), 17'($urandom), 16'($urandom));
        end else if (k < 82) begin
            case ($urandom_range(0, 3))
                0:       seek = $urandom;
                1:       seek = 32'($signed(-$urandom_range(0, 20 << 16)));
                default: seek = 32'($urandom_range(0, 40 << 16));
            endcase
            send_cmd(CMD_START, 20'($urandom), seek, 20'($urandom), 15'($urandom),
                     3'($urandom), 17'($urandom), 16'($urandom));
        end else if (k < 90) begin
            send_cmd(CMD_HOLD, 20'($urandom), $urandom,
                     ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 200000)),
                     ($urandom_range(0, 4) == 0) ? 15'd0 : 15'($urandom),
                     3'($urandom), 17'($urandom), 16'($urandom));
        end else begin
            send_cmd(CMD_LOAD, 20'($urandom), $urandom, 20'($urandom), 15'($urandom),
                     3'($urandom), 17'($urandom_range(0, 65536)), 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n        = 0;
        i_s_tvalid     = 0;
        i_s_tdata      = '0;
        i_s_tuser      = CMD_TICK;
        i_cfg_valid    = 0;
        i_cfg_index    = REG_CLIP;
        i_cfg_data     = '0;
        tx_quiet       = 0;
        rx_quiet       = 0;
        long_stall_req = 0;
        sent           = 0;
        ticks          = 0;
        settings       = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: tick while stopped, full curve load, extremes of each field
        send_cmd(CMD_TICK, 20'hFFFFF, '0, '0, '0, '0, '0, '0);
        for (int i = 0; i < MAX_CURVE_POINTS; i++) begin
            send_cmd(CMD_LOAD, '0, '0, '0, '0, 3'(i),
                     (i == 7) ? T_ONE : (i == 3 ? 17'd24576 : 17'(i * 8192)),
                     (i == 1) ? 16'h8000 : (i == 5 ? 16'h7FFF : 16'(4096 + i * 512)));
        end
        apply_settings(31'(10 << 16), 16'sd4096, 6'b010001, '0, '0, 4'd8);
        send_cmd(CMD_START, '0, '0, '0, '0, '0, '0, '0);
        send_cmd(CMD_TICK, 20'hFFFFF, '0, '0, '0, '0, '0, '0);
        send_cmd(CMD_HOLD, '0, '0, 20'hFFFFF, 15'h7FFF, '0, '0, '0);
        send_cmd(CMD_TICK, 20'd30000, '0, '0, '0, '0, '0, '0);
        send_cmd(CMD_HOLD, '0, '0, 20'd50000, 15'd0, '0, '0, '0);
        send_cmd(CMD_TICK, 20'd30000, '0, '0, '0, '0, '0, '0);
        send_cmd(CMD_HOLD, '0, '0, '0, '0, '0, '0, '0);
        send_cmd(CMD_START, '0, 32'h8000_0000, '0, '0, '0, '0, '0);
        send_cmd(CMD_TICK, 20'd1, '0, '0, '0, '0, '0, '0);
        send_cmd(CMD_START, '0, 32'h7FFF_FFFF, '0, '0, '0, '0, '0);
        send_cmd(CMD_TICK, '0, '0, '0, '0, '0, '0, '0);
        send_cmd(CMD_START, '0, 32'($signed(-(20 << 16))), '0, '0, '0, '0, '0);
        send_cmd(CMD_TICK, 20'd100, '0, '0, '0, '0, '0, '0);

        // random phases over changing settings
        for (int phase = 0; sent < ITEMS; phase++) begin
            if (phase == 0)
                apply_settings('0, 16'h8000, 6'b000010, 32'h8000_0000, 32'h7FFF_FFFF, 4'd0);
            else if (phase == 1)
                apply_settings(31'h7FFF_FFFF, 16'h7FFF, 6'b111111, '0, 32'h7FFF_FFFF, 4'd8);
            else
                random_settings();
            for (int n = 0; n < 40 && sent < ITEMS; n++) begin
                if (sent >= QUIET_FROM) begin
                    tx_quiet = 1;
                    rx_quiet = 1;
                end
                if (phase == 3 && n == 5) long_stall_req = 1;
                if (phase == 5 && n == 20) begin
                    @(negedge i_clk);
                    i_s_tvalid <= 0;
                    while (pending != 0) @(negedge i_clk);
                end
                random_cmd();
            end
        end

        @(negedge i_clk);
        i_s_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        $display("Sent %0d commands (%0d ticks) across %0d register settings;", sent,
                 ticks, settings);
        $display("checked %0d results with %0d mismatches.", results, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
